// ----- rtl/core/pci_config_access_router_defines.svh -----
// Assertion macros used by the checker file of the configuration access router.
`ifndef PCI_CONFIG_ACCESS_ROUTER_DEFINES_SVH
`define PCI_CONFIG_ACCESS_ROUTER_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define PCAR_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("pcar assertion failed");

// Condition must hold in the cycle after the trigger.
`define PCAR_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("pcar assertion failed");

`endif

// ----- rtl/core/pcar_pkg.sv -----
// Package with shared types, codes and sizes of the configuration access router.
`timescale 1ns / 1ps

package pcar_pkg;

    // Table size and index width.
    localparam int NUM_WINDOWS = 8;
    localparam int IDX_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

    // Request action codes.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_ACCESS = 1'b1;

    // Route codes of a result.
    localparam logic [1:0] ROUTE_HIT    = 2'd0;
    localparam logic [1:0] ROUTE_LEGACY = 2'd1;
    localparam logic [1:0] ROUTE_REJECT = 2'd2;

    // Access size codes.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    // Legacy path constants.
    localparam logic [11:0] READ_LIMIT  = 12'h0FC;
    localparam logic [11:0] WRITE_LIMIT = 12'h0FF;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    // One table entry as seen on the read port.
    typedef struct packed {
        logic        valid;
        logic [15:0] segment;
        logic [7:0]  first_bus;
        logic [7:0]  end_bus;
        logic [63:0] base;
    } win_entry_t;

    // Table write request.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] index;
        logic [15:0]      segment;
        logic [7:0]       first_bus;
        logic [7:0]       end_bus;
        logic [63:0]      base;
    } win_load_t;

endpackage

// ----- rtl/core/pci_config_access_router.sv -----
// Top level of the PCI configuration access router.
// A load request writes one window entry in the cycle it is accepted and gives no result;
// busy stays low. An access request first probes the last-hit entry; a hit there goes
// straight to the result state, and otherwise the single compare unit walks the table
// one entry per cycle before the result state, where the one 64-bit adder forms the
// window address. done is registered from the result state, and busy falls in the
// cycle done is high, so a new request may be accepted then. The receiver cannot stall:
// each result is flagged by done for exactly one cycle.
`timescale 1ns / 1ps

module pci_config_access_router (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [2:0]  entry_index,
    input  logic [15:0] segment,
    input  logic [7:0]  bus,
    input  logic [7:0]  end_bus,
    input  logic [63:0] window_base,
    input  logic        is_write,
    input  logic [1:0]  access_size,
    input  logic [4:0]  slot,
    input  logic [2:0]  func,
    input  logic [11:0] offset,
    output logic        done,
    output logic [1:0]  route,
    output logic [63:0] ecam_address,
    output logic [31:0] legacy_address,
    output logic [4:0]  lane_shift,
    output logic        needs_merge,
    output logic [2:0]  hit_entry
);

    localparam int IW = pcar_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(pcar_pkg::NUM_WINDOWS - 1);

    pcar_pkg::state_t state_reg, state_next;

    logic [15:0]   seg_reg;
    logic [7:0]    bus_reg;
    logic          wr_reg;
    logic [1:0]    size_reg;
    logic [4:0]    slot_reg;
    logic [2:0]    func_reg;
    logic [11:0]   off_reg;
    logic [IW-1:0] scan_reg, scan_next;
    logic [IW-1:0] hit_reg, hit_next;
    logic          found_reg, found_next;
    logic [IW-1:0] last_hit_reg, last_hit_next;

    logic        done_reg;
    logic [1:0]  route_reg;
    logic [63:0] ecam_reg;
    logic [31:0] legacy_reg;
    logic [4:0]  lane_reg;
    logic        merge_reg;
    logic [2:0]  hit_entry_reg;

    logic                 accept;
    logic                 emit;
    logic [IW-1:0]        probe_index;
    pcar_pkg::win_entry_t probe_entry;
    pcar_pkg::win_load_t  load;
    logic                 probe_match;

    logic [63:0] ecam_calc;
    logic [31:0] legacy_calc;
    logic [4:0]  lane_calc;
    logic        reject_calc;
    logic [7:0]  bus_rel;

    assign accept = start && !busy;

    // Load requests go straight into the table.
    always_comb
    begin
        load.en        = accept && (action == pcar_pkg::ACT_LOAD) &&
                         (32'(entry_index) < pcar_pkg::NUM_WINDOWS);
        load.index     = IW'(entry_index);
        load.segment   = segment;
        load.first_bus = bus;
        load.end_bus   = end_bus;
        load.base      = window_base;
    end

    pcar_window_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .rd_index (probe_index),
        .rd_entry (probe_entry)
    );

    pcar_window_match u_match (
        .entry   (probe_entry),
        .segment (seg_reg),
        .bus     (bus_reg),
        .match   (probe_match)
    );

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcar_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, probe selection and search bookkeeping.
    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        last_hit_next = last_hit_reg;
        probe_index   = hit_reg;
        busy          = 1'b1;
        emit          = 1'b0;
        case (state_reg)
            pcar_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start && (action == pcar_pkg::ACT_ACCESS))
                begin
                    state_next = pcar_pkg::ST_CHECK;
                end
            end
            pcar_pkg::ST_CHECK:
            begin
                probe_index = last_hit_reg;
                scan_next   = '0;
                if (probe_match)
                begin
                    hit_next   = last_hit_reg;
                    found_next = 1'b1;
                    state_next = pcar_pkg::ST_EMIT;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = pcar_pkg::ST_SEARCH;
                end
            end
            pcar_pkg::ST_SEARCH:
            begin
                probe_index = scan_reg;
                if (probe_match)
                begin
                    hit_next      = scan_reg;
                    found_next    = 1'b1;
                    last_hit_next = scan_reg;
                    state_next    = pcar_pkg::ST_EMIT;
                end
                else if (scan_reg == LAST_IDX)
                begin
                    state_next = pcar_pkg::ST_EMIT;
                end
                else
                begin
                    scan_next = scan_reg + IW'(1);
                end
            end
            pcar_pkg::ST_EMIT:
            begin
                probe_index = hit_reg;
                emit        = 1'b1;
                state_next  = pcar_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pcar_pkg::ST_IDLE;
            end
        endcase
    end

    // Search registers and last-hit index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg     <= '0;
            hit_reg      <= '0;
            found_reg    <= 1'b0;
            last_hit_reg <= '0;
        end
        else
        begin
            scan_reg     <= scan_next;
            hit_reg      <= hit_next;
            found_reg    <= found_next;
            last_hit_reg <= last_hit_next;
        end
    end

    // Request fields held for the duration of an access.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            seg_reg  <= segment;
            bus_reg  <= bus;
            wr_reg   <= is_write;
            size_reg <= access_size;
            slot_reg <= slot;
            func_reg <= func;
            off_reg  <= offset;
        end
    end

    // Window address from the hit entry, wrapping modulo 2^64.
    always_comb
    begin
        bus_rel   = bus_reg - probe_entry.first_bus;
        ecam_calc = probe_entry.base + {36'd0, bus_rel, slot_reg, func_reg, off_reg};
    end

    // Legacy address word, lane shift and reach check.
    always_comb
    begin
        legacy_calc = {1'b1, 7'd0, bus_reg, slot_reg, func_reg, off_reg[7:2], 2'b00};
        case (size_reg)
            pcar_pkg::SIZE_BYTE: lane_calc = {off_reg[1:0], 3'b000};
            pcar_pkg::SIZE_HALF: lane_calc = {off_reg[1], 4'b0000};
            default:             lane_calc = 5'd0;
        endcase
        reject_calc = wr_reg ? (off_reg > pcar_pkg::WRITE_LIMIT)
                             : (off_reg > pcar_pkg::READ_LIMIT);
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= emit;
        end
    end

    // Result fields; unused fields of each route read as zero.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            route_reg     <= pcar_pkg::ROUTE_HIT;
            ecam_reg      <= 64'd0;
            legacy_reg    <= 32'd0;
            lane_reg      <= 5'd0;
            merge_reg     <= 1'b0;
            hit_entry_reg <= 3'd0;
            if (found_reg)
            begin
                ecam_reg      <= ecam_calc;
                hit_entry_reg <= 3'(hit_reg);
            end
            else if (reject_calc)
            begin
                route_reg <= pcar_pkg::ROUTE_REJECT;
            end
            else
            begin
                route_reg  <= pcar_pkg::ROUTE_LEGACY;
                legacy_reg <= legacy_calc;
                lane_reg   <= lane_calc;
                merge_reg  <= wr_reg && (size_reg == pcar_pkg::SIZE_BYTE ||
                                         size_reg == pcar_pkg::SIZE_HALF);
            end
        end
    end

    assign done           = done_reg;
    assign route          = route_reg;
    assign ecam_address   = ecam_reg;
    assign legacy_address = legacy_reg;
    assign lane_shift     = lane_reg;
    assign needs_merge    = merge_reg;
    assign hit_entry      = hit_entry_reg;

endmodule

// ----- rtl/core/pcar_window_table.sv -----
// Window table storage with one write port and one read port.
`timescale 1ns / 1ps

module pcar_window_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pcar_pkg::win_load_t         load,
    input  logic [pcar_pkg::IDX_W-1:0]  rd_index,
    output pcar_pkg::win_entry_t        rd_entry
);

    logic [15:0] segment_reg [pcar_pkg::NUM_WINDOWS];
    logic [7:0]  start_reg   [pcar_pkg::NUM_WINDOWS];
    logic [7:0]  end_reg     [pcar_pkg::NUM_WINDOWS];
    logic [63:0] base_reg    [pcar_pkg::NUM_WINDOWS];
    logic [pcar_pkg::NUM_WINDOWS-1:0] valid_reg;

    // Valid bits are cleared by reset; a load marks its entry valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (load.en)
        begin
            valid_reg[load.index] <= 1'b1;
        end
    end

    // Entry contents are only meaningful while valid, so they carry no reset.
    always_ff @(posedge clk)
    begin
        if (load.en)
        begin
            segment_reg[load.index] <= load.segment;
            start_reg[load.index]   <= load.first_bus;
            end_reg[load.index]     <= load.end_bus;
            base_reg[load.index]    <= load.base;
        end
    end

    // Read port feeding the shared compare unit and the address adder.
    always_comb
    begin
        rd_entry.valid     = valid_reg[rd_index];
        rd_entry.segment   = segment_reg[rd_index];
        rd_entry.first_bus = start_reg[rd_index];
        rd_entry.end_bus   = end_reg[rd_index];
        rd_entry.base      = base_reg[rd_index];
    end

endmodule

// ----- rtl/core/pcar_window_match.sv -----
// Shared compare unit that tests one window entry against the segment and bus.
`timescale 1ns / 1ps

module pcar_window_match (
    input  pcar_pkg::win_entry_t entry,
    input  logic [15:0]          segment,
    input  logic [7:0]           bus,
    output logic                 match
);

    // An empty or reversed window fails the range test on its own.
    assign match = entry.valid && (segment == entry.segment) &&
                   (bus >= entry.first_bus) && (bus <= entry.end_bus);

endmodule

// ----- rtl/core/pcar_checker.sv -----
// Port-level checker for the configuration access router, bound to the top level.
`timescale 1ns / 1ps
`include "pci_config_access_router_defines.svh"

module pcar_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        action,
    input logic        done,
    input logic [1:0]  route,
    input logic [63:0] ecam_address,
    input logic [31:0] legacy_address,
    input logic [4:0]  lane_shift,
    input logic        needs_merge,
    input logic [2:0]  hit_entry
);

    // An accepted access keeps the block busy in the following cycle.
    `PCAR_ASSERT_NEXT(a_access_busy, start && !busy && action == pcar_pkg::ACT_ACCESS, busy)

    // A result strobe lasts a single cycle.
    `PCAR_ASSERT_NEXT(a_done_pulse, done, !done)

    // A window hit leaves the legacy fields clear.
    `PCAR_ASSERT_NOW(a_hit_fields, done && route == pcar_pkg::ROUTE_HIT, legacy_address == 32'd0 && lane_shift == 5'd0 && !needs_merge)

    // Without a hit the window address and entry index are clear.
    `PCAR_ASSERT_NOW(a_miss_fields, done && route != pcar_pkg::ROUTE_HIT, ecam_address == 64'd0 && hit_entry == 3'd0)

    // A legacy address word always carries the enable bit.
    `PCAR_ASSERT_NOW(a_legacy_enable, done && route == pcar_pkg::ROUTE_LEGACY, legacy_address[31])

endmodule

bind pci_config_access_router pcar_checker u_pcar_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .done           (done),
    .route          (route),
    .ecam_address   (ecam_address),
    .legacy_address (legacy_address),
    .lane_shift     (lane_shift),
    .needs_merge    (needs_merge),
    .hit_entry      (hit_entry)
);
